@@ hw/rtl/m4vt_pkg.sv @@
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types and constants for the 4x4 matrix by vector transform.
// ----------------------------------------------------------------------------
`default_nettype none

package m4vt_pkg;

  localparam int ELEMENT_WIDTH = 32;
  localparam int FRACTION_BITS = 16;

  localparam int NUM_LANES  = 4;
  localparam int NUM_WORDS  = 8;
  localparam int SLOT_W     = 32;
  localparam int CFG_DATA_W = 64;
  localparam int WORD_IDX_W = $clog2(NUM_WORDS);
  localparam int CFG_ADDR_W = WORD_IDX_W + 3;

  localparam int PROD_W = 2 * ELEMENT_WIDTH;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SHR_W  = SUM_W - FRACTION_BITS;

  // Register stages in a lane: product, pair sum, full sum, clamped result
  localparam int LANE_DEPTH = 4;

  // Configuration word that holds row r, columns 2k and 2k+1
  localparam logic [WORD_IDX_W-1:0] WORD_OF [NUM_LANES][2] = '{
    '{WORD_IDX_W'(0), WORD_IDX_W'(1)},
    '{WORD_IDX_W'(2), WORD_IDX_W'(3)},
    '{WORD_IDX_W'(5), WORD_IDX_W'(4)},
    '{WORD_IDX_W'(6), WORD_IDX_W'(7)}
  };

  // Identity matrix in Q16.16
  localparam logic [CFG_DATA_W-1:0] RESET_WORDS [NUM_WORDS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
  typedef elem_t [NUM_LANES-1:0]            row_t;
  typedef row_t  [NUM_LANES-1:0]            matrix_t;

  typedef struct packed {
    logic signed [SLOT_W-1:0] vec_x;
    logic signed [SLOT_W-1:0] vec_y;
    logic signed [SLOT_W-1:0] vec_z;
    logic signed [SLOT_W-1:0] vec_w;
  } in_item_t;

  typedef struct packed {
    logic signed [SLOT_W-1:0] out_x;
    logic signed [SLOT_W-1:0] out_y;
    logic signed [SLOT_W-1:0] out_z;
    logic signed [SLOT_W-1:0] out_w;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic                     sat;
    logic signed [SLOT_W-1:0] value;
  } lane_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/m4vt_regs.sv @@
// ----------------------------------------------------------------------------
// m4vt_regs
// APB register file for the eight 64-bit matrix words; unpacks the matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module m4vt_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [m4vt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [m4vt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [m4vt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output m4vt_pkg::matrix_t                     matrix
);
  import m4vt_pkg::*;

  logic [CFG_DATA_W-1:0] words_r   [NUM_WORDS];
  logic [CFG_DATA_W-1:0] words_nxt [NUM_WORDS];
  logic [WORD_IDX_W-1:0] word_idx;
  logic                  wr_en;

  assign word_idx = paddr[CFG_ADDR_W-1:3];
  assign wr_en    = psel & penable & pwrite;
  assign pready   = 1'b1;
  assign prdata   = words_r[word_idx];

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      words_nxt[i] = words_r[i];
    end
    if (wr_en) begin
      words_nxt[word_idx] = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      if (!rst_n) begin
        words_r[i] <= RESET_WORDS[i];
      end else begin
        words_r[i] <= words_nxt[i];
      end
    end
  end

  // Element takes the low bits of its 32-bit half
  for (genvar r = 0; r < NUM_LANES; r++) begin : g_row
    for (genvar c = 0; c < NUM_LANES; c++) begin : g_col
      assign matrix[r][c] = words_r[WORD_OF[r][c/2]][SLOT_W*(c%2) +: ELEMENT_WIDTH];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/m4vt_lane.sv @@
// ----------------------------------------------------------------------------
// m4vt_lane
// One row lane: four products, two-level adder tree, shift and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module m4vt_lane (
  input  wire logic            clk,
  input  m4vt_pkg::row_t       row,
  input  m4vt_pkg::row_t       vec,
  output m4vt_pkg::lane_res_t  res
);
  import m4vt_pkg::*;

  logic signed [PROD_W-1:0]        prod_r [NUM_LANES];
  logic signed [PAIR_W-1:0]        pair_r [2];
  logic signed [SUM_W-1:0]         sum_r;
  logic signed [SHR_W-1:0]         shr;
  logic signed [ELEMENT_WIDTH-1:0] clamp;
  logic                            sat;
  lane_res_t                       res_r;

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_LANES; c++) begin
      prod_r[c] <= $signed(row[c]) * $signed(vec[c]);
    end
    pair_r[0] <= $signed({prod_r[0][PROD_W-1], prod_r[0]})
               + $signed({prod_r[1][PROD_W-1], prod_r[1]});
    pair_r[1] <= $signed({prod_r[2][PROD_W-1], prod_r[2]})
               + $signed({prod_r[3][PROD_W-1], prod_r[3]});
    sum_r     <= $signed({pair_r[0][PAIR_W-1], pair_r[0]})
               + $signed({pair_r[1][PAIR_W-1], pair_r[1]});
    res_r     <= '{sat: sat, value: SLOT_W'(clamp)};
  end

  // Arithmetic shift right, rounding toward minus infinity
  assign shr = sum_r[SUM_W-1:FRACTION_BITS];

  if (SHR_W > ELEMENT_WIDTH) begin : g_clamp
    logic [SHR_W-ELEMENT_WIDTH:0] top_bits;
    assign top_bits = shr[SHR_W-1:ELEMENT_WIDTH-1];
    always_comb begin
      sat   = !((&top_bits) || !(|top_bits));
      clamp = shr[ELEMENT_WIDTH-1:0];
      if (sat) begin
        clamp = shr[SHR_W-1] ? {1'b1, {(ELEMENT_WIDTH-1){1'b0}}}
                             : {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
      end
    end
  end else begin : g_fit
    assign sat   = 1'b0;
    assign clamp = ELEMENT_WIDTH'(shr);
  end

  assign res = res_r;

endmodule

`default_nettype wire

@@ hw/rtl/m4vt_merge.sv @@
// ----------------------------------------------------------------------------
// m4vt_merge
// Combines the four lane results and the saturation flags into one item.
// ----------------------------------------------------------------------------
`default_nettype none

module m4vt_merge (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           res_valid,
  input  m4vt_pkg::lane_res_t res [m4vt_pkg::NUM_LANES],
  output logic                out_valid,
  output m4vt_pkg::out_item_t out_data
);
  import m4vt_pkg::*;

  logic      valid_r;
  out_item_t data_r;
  out_item_t data_nxt;
  logic      any_sat;

  always_comb begin
    any_sat = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      any_sat = any_sat | res[i].sat;
    end
    data_nxt = '{out_x:     res[0].value,
                 out_y:     res[1].value,
                 out_z:     res[2].value,
                 out_w:     res[3].value,
                 saturated: any_sat};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= res_valid;
    end
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ hw/rtl/matrix4_vector_transform.sv @@
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// 4x4 matrix by 4-vector product in signed fixed point, one lane per row.
// ----------------------------------------------------------------------------
// An accepted item passes the lane registers and then the merge register.
// Throughput: one item per cycle; busy never rises, four row lanes of 32x32
// multipliers and adder trees run fully pipelined.
// Reset empties the pipeline and loads the identity matrix.
`default_nettype none

module matrix4_vector_transform (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  m4vt_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  output m4vt_pkg::out_item_t                   out_data,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [m4vt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [m4vt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [m4vt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import m4vt_pkg::*;

  matrix_t   matrix;
  row_t      vec;
  lane_res_t lane_res [NUM_LANES];
  logic [LANE_DEPTH-1:0] valid_r;
  logic [LANE_DEPTH-1:0] valid_nxt;

  assign busy = 1'b0;

  assign vec[0] = in_data.vec_x[ELEMENT_WIDTH-1:0];
  assign vec[1] = in_data.vec_y[ELEMENT_WIDTH-1:0];
  assign vec[2] = in_data.vec_z[ELEMENT_WIDTH-1:0];
  assign vec[3] = in_data.vec_w[ELEMENT_WIDTH-1:0];

  m4vt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .matrix  (matrix)
  );

  for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
    m4vt_lane u_lane (
      .clk (clk),
      .row (matrix[r]),
      .vec (vec),
      .res (lane_res[r])
    );
  end

  // Track each item through the lane stages
  assign valid_nxt = {valid_r[LANE_DEPTH-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  m4vt_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (valid_r[LANE_DEPTH-1]),
    .res       (lane_res),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4x4 matrix by vector transform. A queue-fed
// driver streams vectors with random gaps, a monitor predicts each product
// with a wide-integer model of the matrix and checks every result in order.
// The matrix is reprogrammed between phases over the APB port and read back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import m4vt_pkg::*;

  localparam int PIPE_LATENCY = 5;
  localparam int CYCLE_LIMIT  = 60000;
  localparam int NUM_PHASES   = 9;
  localparam int RANDOM_ITEMS = 138;

  typedef enum int {
    MAT_IDENTITY,
    MAT_ALL_MIN,
    MAT_ALL_MAX,
    MAT_ZERO,
    MAT_FULL_RANDOM,
    MAT_SMALL_RANDOM,
    MAT_MIXED
  } mat_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  in_item_t pending_vecs[$];
  out_item_t expected_results[$];
  out_item_t expected_head;
  logic [63:0] mat_words [8];

  logic item_taken = 1'b0;
  bit hold_sender = 1'b0;
  bit no_idle = 1'b0;
  int fault_count = 0;
  int accepted_count = 0;
  int sat_count = 0;
  int setting_count = 0;
  int cycle_count = 0;

  matrix4_vector_transform u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  // Row 2 stores its column pairs in swapped word order
  function automatic int word_for(int row, int half);
    if (row == 2) begin
      return half ? 4 : 5;
    end
    return 2 * row + half;
  endfunction

  function automatic logic signed [63:0] widen_elem(logic [31:0] slot);
    logic [63:0] t;
    t = {32'b0, slot} << (64 - ELEMENT_WIDTH);
    return $signed(t) >>> (64 - ELEMENT_WIDTH);
  endfunction

  function automatic out_item_t transform_vector(in_item_t v);
    logic signed [63:0] comp [4];
    logic signed [127:0] acc, ea, eb, scaled, lim_hi, lim_lo;
    logic [63:0] word;
    logic [31:0] slot;
    logic [31:0] lane [4];
    logic sat;
    out_item_t r;
    comp[0] = widen_elem(v.vec_x);
    comp[1] = widen_elem(v.vec_y);
    comp[2] = widen_elem(v.vec_z);
    comp[3] = widen_elem(v.vec_w);
    lim_hi = (128'sd1 <<< (ELEMENT_WIDTH - 1)) - 128'sd1;
    lim_lo = -lim_hi - 128'sd1;
    sat = 1'b0;
    for (int row = 0; row < 4; row++) begin
      acc = '0;
      for (int col = 0; col < 4; col++) begin
        word = mat_words[word_for(row, col / 2)];
        slot = (col % 2) ? word[63:32] : word[31:0];
        ea = 128'(widen_elem(slot));
        eb = 128'(comp[col]);
        acc = acc + ea * eb;
      end
      // exact sum, floor shift, then clamp
      scaled = acc >>> FRACTION_BITS;
      if (scaled > lim_hi) begin
        scaled = lim_hi;
        sat = 1'b1;
      end else if (scaled < lim_lo) begin
        scaled = lim_lo;
        sat = 1'b1;
      end
      lane[row] = scaled[31:0];
    end
    r.out_x = lane[0];
    r.out_y = lane[1];
    r.out_z = lane[2];
    r.out_w = lane[3];
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [31:0] pick_component(int mode);
    logic [31:0] b;
    b = $urandom;
    case (mode)
      0: return b;
      1: return {{12{b[19]}}, b[19:0]};
      default: begin
        case ($urandom_range(5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0000_0001;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  function automatic in_item_t random_vector();
    int pick;
    int mode;
    in_item_t v;
    pick = $urandom_range(9);
    mode = (pick < 5) ? 0 : (pick < 8) ? 1 : 2;
    v.vec_x = pick_component(mode);
    v.vec_y = pick_component(mode);
    v.vec_z = pick_component(mode);
    v.vec_w = pick_component(mode);
    return v;
  endfunction

  function automatic logic [31:0] make_element(mat_style_t style, int row, int col);
    logic [31:0] b;
    b = $urandom;
    case (style)
      MAT_IDENTITY:     return (row == col) ? 32'h0001_0000 : 32'h0;
      MAT_ALL_MIN:      return 32'h8000_0000;
      MAT_ALL_MAX:      return 32'h7FFF_FFFF;
      MAT_ZERO:         return 32'h0;
      MAT_FULL_RANDOM:  return b;
      MAT_SMALL_RANDOM: return {{12{b[19]}}, b[19:0]};
      default:          return pick_component(2 * ($urandom_range(6) != 0));
    endcase
  endfunction

  task automatic record_fault(string what, logic [63:0] want, logic [63:0] got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("[%0d] %s: expected %h, got %h", cycle_count, what, want, got);
    end
  endtask

  task automatic push_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
    in_item_t v;
    v.vec_x = x;
    v.vec_y = y;
    v.vec_z = z;
    v.vec_w = w;
    pending_vecs.push_back(v);
  endtask

  task automatic apb_access(int idx, bit is_write, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= CFG_ADDR_W'(idx * 8);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (is_write) begin
      mat_words[idx] = val;
    end else if (prdata !== mat_words[idx]) begin
      record_fault("register read back", mat_words[idx], prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_matrix(mat_style_t style, bit to_dut);
    logic [63:0] w;
    for (int row = 0; row < 4; row++) begin
      for (int half = 0; half < 2; half++) begin
        w = {make_element(style, row, 2 * half + 1), make_element(style, row, 2 * half)};
        if (to_dut) begin
          apb_access(word_for(row, half), 1'b1, w);
        end else begin
          mat_words[word_for(row, half)] = w;
        end
      end
    end
    if (to_dut) begin
      for (int idx = 0; idx < 8; idx++) begin
        apb_access(idx, 1'b0, '0);
      end
    end
    setting_count++;
  endtask

  // Hold until the pipe is empty and every expected item has come back
  task automatic drain_pipe();
    do @(posedge clk);
    while (pending_vecs.size() != 0 || start || expected_results.size() != 0);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Driver: one item per accept, random gaps unless asked not to
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // hold the item until accepted
    end else if (hold_sender || pending_vecs.size() == 0 ||
                 (!no_idle && $urandom_range(99) < 23)) begin
      start <= 1'b0;
      in_data <= {$urandom, $urandom, $urandom, $urandom};
    end else begin
      start <= 1'b1;
      in_data <= pending_vecs.pop_front();
    end
  end

  // Monitor: check results against the oldest prediction, predict new items
  always @(posedge clk) begin
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      if (out_valid !== 1'b0) begin
        if (expected_results.size() == 0) begin
          record_fault("result with nothing pending", '0, 64'(out_data[31:0]));
        end else begin
          expected_head = expected_results.pop_front();
          if (out_data.out_x !== expected_head.out_x)
            record_fault("out_x", 64'(expected_head.out_x), 64'(out_data.out_x));
          if (out_data.out_y !== expected_head.out_y)
            record_fault("out_y", 64'(expected_head.out_y), 64'(out_data.out_y));
          if (out_data.out_z !== expected_head.out_z)
            record_fault("out_z", 64'(expected_head.out_z), 64'(out_data.out_z));
          if (out_data.out_w !== expected_head.out_w)
            record_fault("out_w", 64'(expected_head.out_w), 64'(out_data.out_w));
          if (out_data.saturated !== expected_head.saturated)
            record_fault("saturated", 64'(expected_head.saturated),
                         64'(out_data.saturated));
          if (expected_head.saturated) sat_count++;
        end
      end
      item_taken <= start && !busy;
      if (start && !busy) begin
        expected_results.push_back(transform_vector(in_data));
        accepted_count++;
      end
    end
  end

  initial begin
    mat_style_t style;
    program_matrix(MAT_IDENTITY, 1'b0);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       style = MAT_IDENTITY;
        1:       style = MAT_ALL_MIN;
        2:       style = MAT_ALL_MAX;
        3:       style = MAT_ZERO;
        4:       style = MAT_FULL_RANDOM;
        5:       style = MAT_SMALL_RANDOM;
        6:       style = MAT_MIXED;
        7:       style = MAT_FULL_RANDOM;
        default: style = MAT_IDENTITY;
      endcase
      // the reset matrix serves the first phase
      if (phase != 0) begin
        drain_pipe();
        program_matrix(style, 1'b1);
      end
      no_idle = (phase == 3);
      if (phase < 3) begin
        push_vec(32'h0, 32'h0, 32'h0, 32'h0);
        push_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        push_vec(32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        if (phase == 4 && i == RANDOM_ITEMS / 2) begin
          drain_pipe();
        end
        pending_vecs.push_back(random_vector());
      end
    end

    drain_pipe();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (expected_results.size() != 0) begin
      record_fault("results never arrived", 64'(expected_results.size()), '0);
    end
    $display("run covered %0d vectors over %0d matrix settings, %0d saturated results",
             accepted_count, setting_count, sat_count);
    $display("faults seen: %0d", fault_count);
    if (fault_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
